// ----- src/omni_wheel_inverse_kinematics_top_assert.svh -----
// assertion macros shared by the omni wheel checker
// used by owk_checker; needs clk and rst in scope
`ifndef OMNI_WHEEL_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define OMNI_WHEEL_INVERSE_KINEMATICS_TOP_ASSERT_SVH
// antecedent implies consequent in the same cycle
`define OWK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the following cycle
`define OWK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/owk_pkg.sv -----
// shared types, constants and helpers for the omni wheel inverse kinematics block
// no dependencies
package owk_pkg;

  localparam int NSTG    = 15;   // quotient bits of the scaling divider
  localparam int LATENCY = 20;   // accept to result strobe, in cycles

  localparam logic signed [37:0] C_TWO_THIRDS   = 38'sd43691;
  localparam logic signed [37:0] C_ONE_THIRD    = 38'sd21845;
  localparam logic signed [37:0] C_ROOT3_OVER3  = 38'sd37837;

  localparam logic [15:0] GAIN_RESET  = 16'd4096;
  localparam logic [14:0] LIMIT_RESET = 15'd2560;

  localparam logic REG_ROTATION_GAIN = 1'b0;
  localparam logic REG_SPEED_LIMIT   = 1'b1;

  // one request after the matrix and magnitude work, waiting for the divider
  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][52:0]  num;
    logic [37:0]       den;
    logic [2:0][15:0]  plain;
    logic              scaled;
  } owk_job_t;

  // apply sign to a magnitude and saturate to signed q8.8
  function automatic logic [15:0] sat_q88(input logic neg, input logic [21:0] mag);
    logic [15:0] r;
    if (neg) begin
      if (mag > 22'd32768) r = 16'h8000;
      else r = 16'(~mag + 22'd1);
    end else begin
      if (mag > 22'd32767) r = 16'h7fff;
      else r = mag[15:0];
    end
    return r;
  endfunction

endpackage

// ----- src/owk_front.sv -----
// front end: wheel matrix products, sums, magnitudes, limit check, scaling operands
// depends on owk_pkg
module owk_front import owk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] rot_z,
  input  logic [15:0]        rotation_gain,
  input  logic [14:0]        wheel_speed_limit,
  output logic               job_valid,
  output owk_job_t           job
);

  logic               v1, v2;
  logic signed [37:0] py2, py1, px, rg;
  logic [14:0]        lim1, lim2;
  logic signed [37:0] sum [3];
  logic [2:0]         neg_next, neg2;
  logic [36:0]        mag_next [3];
  logic [36:0]        mag2 [3];
  logic [36:0]        largest_next, largest2;
  logic               scaled_next, scaled2;
  logic [2:0][15:0]   plain_next, plain2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      job_valid <= v2;
    end
    py2  <= 38'(vel_y) * C_TWO_THIRDS;
    py1  <= 38'(vel_y) * C_ONE_THIRD;
    px   <= 38'(vel_x) * C_ROOT3_OVER3;
    rg   <= 38'(rot_z) * $signed({22'd0, rotation_gain});
    lim1 <= wheel_speed_limit;
  end

  always_comb begin
    sum[0] = py2 + (rg <<< 4);
    sum[1] = px - py1 + (rg <<< 4);
    sum[2] = -px - py1 + (rg <<< 4);
    for (int i = 0; i < 3; i++) begin
      neg_next[i] = sum[i][37];
      mag_next[i] = neg_next[i] ? 37'(-sum[i]) : 37'(sum[i]);
      plain_next[i] = sat_q88(neg_next[i], 22'((38'(mag_next[i]) + 38'd32768) >> 16));
    end
    // ties count as largest
    largest_next = mag_next[0];
    if (mag_next[1] >= largest_next) largest_next = mag_next[1];
    if (mag_next[2] >= largest_next) largest_next = mag_next[2];
    scaled_next = largest_next > 37'({lim1, 16'd0});
  end

  always_ff @(posedge clk) begin
    neg2     <= neg_next;
    mag2     <= mag_next;
    largest2 <= largest_next;
    scaled2  <= scaled_next;
    plain2   <= plain_next;
    lim2     <= lim1;
  end

  // numerator 2*m*lim + largest over 2*largest rounds to nearest
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      job.num[i] <= {52'(mag2[i]) * 52'(lim2), 1'b0} + 53'(largest2);
    end
    job.den    <= {largest2, 1'b0};
    job.neg    <= neg2;
    job.plain  <= plain2;
    job.scaled <= scaled2;
  end

endmodule

// ----- src/owk_queue.sv -----
// two-entry request queue between front end and divider
// depends on owk_pkg
module owk_queue import owk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  owk_job_t push_data,
  input  logic     pop,
  output owk_job_t head,
  output logic     not_empty,
  output logic     full
);

  owk_job_t   mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/owk_back.sv -----
// back end: pipelined restoring divider for limit scaling, one quotient bit per stage
// depends on owk_pkg
module owk_back import owk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  owk_job_t    job,
  output logic        done,
  output logic [15:0] wheel1_speed,
  output logic [15:0] wheel2_speed,
  output logic [15:0] wheel3_speed,
  output logic        was_scaled
);

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][52:0]  rem;
    logic [2:0][14:0]  quo;
    logic [37:0]       den;
    logic [2:0][15:0]  plain;
    logic              scaled;
  } div_stage_t;

  div_stage_t stg      [NSTG];
  div_stage_t stg_next [NSTG];
  logic       vld      [NSTG];

  always_comb begin
    div_stage_t src;
    logic [52:0] sh;
    for (int st = 0; st < NSTG; st++) begin
      if (st == 0) begin
        src.neg    = job.neg;
        src.rem    = job.num;
        src.quo    = '0;
        src.den    = job.den;
        src.plain  = job.plain;
        src.scaled = job.scaled;
      end else begin
        src = stg[st-1];
      end
      stg_next[st] = src;
      sh = 53'(src.den) << (NSTG - 1 - st);
      for (int l = 0; l < 3; l++) begin
        if (src.rem[l] >= sh) begin
          stg_next[st].rem[l] = src.rem[l] - sh;
          stg_next[st].quo[l][NSTG-1-st] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int st = 0; st < NSTG; st++) vld[st] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= job_valid;
      for (int st = 1; st < NSTG; st++) vld[st] <= vld[st-1];
      done <= vld[NSTG-1];
    end
    for (int st = 0; st < NSTG; st++) stg[st] <= stg_next[st];
  end

  // final select between scaled quotient and plain rounded value
  always_ff @(posedge clk) begin
    wheel1_speed <= stg[NSTG-1].scaled
                    ? sat_q88(stg[NSTG-1].neg[0], 22'(stg[NSTG-1].quo[0]))
                    : stg[NSTG-1].plain[0];
    wheel2_speed <= stg[NSTG-1].scaled
                    ? sat_q88(stg[NSTG-1].neg[1], 22'(stg[NSTG-1].quo[1]))
                    : stg[NSTG-1].plain[1];
    wheel3_speed <= stg[NSTG-1].scaled
                    ? sat_q88(stg[NSTG-1].neg[2], 22'(stg[NSTG-1].quo[2]))
                    : stg[NSTG-1].plain[2];
    was_scaled   <= stg[NSTG-1].scaled;
  end

endmodule

// ----- src/omni_wheel_inverse_kinematics_top.sv -----
// top level of the three-wheel omni drive inverse kinematics block
// depends on owk_pkg, owk_front, owk_queue, owk_back
// One request is taken on any cycle with start high and busy low, so commands may follow
// back to back, one per clock. Each result appears for one cycle with done high; the
// receiver cannot stall it. The path runs through three front stages (products, wheel sums
// and limit check, scaling numerator), one queue slot, a fifteen-stage restoring divider
// that produces one quotient bit per stage and the output register. Registers: index 0
// rotation gain (unsigned q4.12), index 1 wheel speed limit (unsigned q7.8); write them
// only while no request is in flight.
module omni_wheel_inverse_kinematics_top import owk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] rot_z,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] wheel1_speed,
  output logic signed [15:0] wheel2_speed,
  output logic signed [15:0] wheel3_speed,
  output logic               was_scaled
);

  logic [15:0] rotation_gain;
  logic [14:0] wheel_speed_limit;
  logic        job_valid, q_not_empty, q_full;
  owk_job_t    job, head;
  logic [15:0] w1, w2, w3;

  assign busy = rst | q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_gain     <= GAIN_RESET;
      wheel_speed_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROTATION_GAIN: rotation_gain     <= cfg_data;
        REG_SPEED_LIMIT:   wheel_speed_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  owk_front u_front (
    .clk, .rst,
    .in_valid(start & ~busy),
    .vel_x, .vel_y, .rot_z,
    .rotation_gain, .wheel_speed_limit,
    .job_valid, .job
  );

  owk_queue u_queue (
    .clk, .rst,
    .push(job_valid), .push_data(job),
    .pop(q_not_empty), .head,
    .not_empty(q_not_empty), .full(q_full)
  );

  owk_back u_back (
    .clk, .rst,
    .job_valid(q_not_empty), .job(head),
    .done,
    .wheel1_speed(w1), .wheel2_speed(w2), .wheel3_speed(w3),
    .was_scaled
  );

  assign wheel1_speed = $signed(w1);
  assign wheel2_speed = $signed(w2);
  assign wheel3_speed = $signed(w3);

endmodule

// ----- src/owk_checker.sv -----
// port level checker for the omni wheel block, bound to the top level
// depends on owk_pkg and omni_wheel_inverse_kinematics_top_assert.svh
`include "omni_wheel_inverse_kinematics_top_assert.svh"
module owk_checker import owk_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every request gives exactly one result
  `OWK_ASSERT_NOW(a_latency, start && !busy, ##LATENCY done, "result missing after request")
  `OWK_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, LATENCY), "result without request")
  // queue drains every cycle so it never fills
  `OWK_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "request queue filled")

endmodule

bind omni_wheel_inverse_kinematics_top owk_checker u_owk_checker (
  .clk, .rst, .start, .busy, .done
);

// ----- tb/omni_wheel_inverse_kinematics_top_test.sv -----
// self-checking testbench for the omni wheel inverse kinematics block
// depends on owk_pkg and omni_wheel_inverse_kinematics_top; predicts wheel speeds per request
module omni_wheel_inverse_kinematics_top_test;
  import owk_pkg::*;

  class wheel_scoreboard;
    logic [15:0] gain;
    logic [14:0] limit;
    logic [15:0] want1[$], want2[$], want3[$];
    logic        want_scaled[$];
    int          errors;

    function new();
      gain = GAIN_RESET;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function int pending();
      return want_scaled.size();
    endfunction

    // work out the wheel speeds for one accepted request
    function void note_request(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
      longint rot, largest, lim, q, r;
      longint s[3];
      longint m[3];
      logic [15:0] w[3];
      logic scl;
      rot = longint'(z) * longint'(gain) * 16;
      s[0] = 43691 * longint'(y) + rot;
      s[1] = 37837 * longint'(x) - 21845 * longint'(y) + rot;
      s[2] = -37837 * longint'(x) - 21845 * longint'(y) + rot;
      largest = 0;
      lim = longint'(limit);
      for (int i = 0; i < 3; i++) begin
        m[i] = s[i] < 0 ? -s[i] : s[i];
        if (m[i] > largest) largest = m[i];
      end
      scl = largest > (lim << 16);
      for (int i = 0; i < 3; i++) begin
        if (scl) q = (m[i] * lim * 2 + largest) / (2 * largest);
        else q = (m[i] + 32768) >>> 16;
        r = s[i] < 0 ? -q : q;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        w[i] = r[15:0];
      end
      want1.push_back(w[0]);
      want2.push_back(w[1]);
      want3.push_back(w[2]);
      want_scaled.push_back(scl);
    endfunction

    function void check_result(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3, logic as);
      logic [15:0] e1, e2, e3;
      logic es;
      if (want_scaled.size() == 0) begin
        $error("unexpected result w1=%0h w2=%0h w3=%0h", a1, a2, a3);
        errors++;
        return;
      end
      e1 = want1.pop_front();
      e2 = want2.pop_front();
      e3 = want3.pop_front();
      es = want_scaled.pop_front();
      if (a1 !== e1) begin
        $error("wheel1_speed expected %0h actual %0h", e1, a1);
        errors++;
      end
      if (a2 !== e2) begin
        $error("wheel2_speed expected %0h actual %0h", e2, a2);
        errors++;
      end
      if (a3 !== e3) begin
        $error("wheel3_speed expected %0h actual %0h", e3, a3);
        errors++;
      end
      if (as !== es) begin
        $error("was_scaled expected %0b actual %0b", es, as);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] vel_x = '0, vel_y = '0, rot_z = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_ROTATION_GAIN;
  logic [15:0] cfg_data = '0;
  logic done, was_scaled;
  logic signed [15:0] wheel1_speed, wheel2_speed, wheel3_speed;

  wheel_scoreboard sb = new();
  longint cycles = 0;
  int gap_left = 0;

  omni_wheel_inverse_kinematics_top dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && done) sb.check_result(wheel1_speed, wheel2_speed, wheel3_speed, was_scaled);
  end

  // one request; sender gaps in bursts
  task automatic send(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if (gap_left > 0) begin
      start <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      gap_left = $urandom_range(1, 30);
    end
    start <= 1'b1;
    vel_x <= x;
    vel_y <= y;
    rot_z <= z;
    do @(posedge clk); while (busy);
    sb.note_request(x, y, z);
    // keep start up if another request follows at once; caller lowers it
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROTATION_GAIN) sb.gain = val;
    else sb.limit = val[14:0];
  endtask

  task automatic random_phase(int n);
    logic [15:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
        end
        1: begin
          // small commands stay mostly below the limit
          x = 16'($signed($urandom_range(0, 2047)) - 1024);
          y = 16'($signed($urandom_range(0, 2047)) - 1024);
          z = 16'($signed($urandom_range(0, 1023)) - 512);
        end
        2: begin
          x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          y = 16'($urandom);
          z = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
        end
        default: begin
          x = 16'($signed($urandom_range(0, 8191)) - 4096);
          y = 16'($signed($urandom_range(0, 8191)) - 4096);
          z = 16'($signed($urandom_range(0, 4095)) - 2048);
        end
      endcase
      send(x, y, z);
      if (gap_left > 0) start <= 1'b0;
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zeros, ties, limit edge
    send(16'h0000, 16'h0000, 16'h0000);
    send(16'h7fff, 16'h7fff, 16'h7fff);
    send(16'h8000, 16'h8000, 16'h8000);
    send(16'h7fff, 16'h8000, 16'h0000);
    send(16'h8000, 16'h7fff, 16'h0000);
    send(16'h0000, 16'h0000, 16'h0a00);
    send(16'h0000, 16'h0000, 16'h0a01);
    send(16'h0000, 16'h0000, 16'hf600);
    send(16'h0100, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0100, 16'h0000);
    send(16'hffff, 16'hffff, 16'hffff);
    send(16'h0000, 16'h0000, 16'h0001);
    drain();
    write_reg(REG_SPEED_LIMIT, 16'h0000);
    send(16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0000, 16'h0001);
    send(16'h7fff, 16'h1234, 16'h8000);
    drain();
    write_reg(REG_SPEED_LIMIT, 16'hffff);
    write_reg(REG_ROTATION_GAIN, 16'hffff);
    send(16'h0000, 16'h0000, 16'h7fff);
    send(16'h0000, 16'h0000, 16'h8000);
    send(16'h7fff, 16'h7fff, 16'h7fff);
    drain();
    write_reg(REG_ROTATION_GAIN, 16'h0000);
    send(16'h1234, 16'h8000, 16'h7fff);
    drain();

    write_reg(REG_ROTATION_GAIN, GAIN_RESET);
    write_reg(REG_SPEED_LIMIT, {1'b0, LIMIT_RESET});
    random_phase(400);
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_ROTATION_GAIN, 16'($urandom));
      write_reg(REG_SPEED_LIMIT, p == 0 ? 16'h0001 : 16'($urandom_range(0, 32767)));
      random_phase(260);
    end

    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
